// ===== rtl/qau_pkg.sv =====
// qau_pkg: payload type, angle constants and arctangent table for the attitude update pipeline
`default_nettype none

package qau_pkg;

  // configuration register indexes
  localparam logic CFG_STEP_TIME   = 1'b0;
  localparam logic CFG_SMALL_LIMIT = 1'b1;

  localparam logic [31:0] STEP_TIME_RST   = 32'd42949673;
  localparam logic [15:0] SMALL_LIMIT_RST = 16'd1;

  // angles in q.30 radians
  localparam logic [32:0]        TWO_PI_U = 33'd6746518852;
  localparam logic signed [34:0] ANG_TWO  = 35'sd6746518852;
  localparam logic signed [34:0] ANG_PI   = 35'sd3373259426;
  localparam logic signed [34:0] ANG_HALF = 35'sd1686629713;
  localparam logic [33:0]        GAIN     = 34'd652032874;
  localparam logic [31:0]        ONE_Q30  = 32'h4000_0000;

  // everything one item carries down the pipeline
  typedef struct packed {
    logic [3:0][31:0]  q;
    logic [2:0][31:0]  r;
    logic [65:0]       a;
    logic [31:0]       root;
    logic [31:0]       om;
    logic              small_ang;
    logic              negc;
    logic              zero;
    logic [38:0]       ang;
    logic [33:0]       cx;
    logic [33:0]       cy;
    logic [33:0]       cz;
    logic [3:0][36:0]  dv;
    logic [3:0][63:0]  num;
    logic [3:0][31:0]  quo;
    logic [31:0]       den;
    logic [15:0][63:0] pr;
    logic [3:0][63:0]  p;
    logic [3:0]        pneg;
    logic [3:0][63:0]  cm;
    logic [63:0]       m;
    logic [63:0]       m2;
    logic [3:0][31:0]  res;
  } item_t;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] v;
    case (i)
      0:  v = 30'd843314856;
      1:  v = 30'd497837829;
      2:  v = 30'd263043836;
      3:  v = 30'd133525158;
      4:  v = 30'd67021686;
      5:  v = 30'd33543515;
      6:  v = 30'd16775850;
      7:  v = 30'd8388437;
      8:  v = 30'd4194282;
      9:  v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      24: v = 30'd63;
      25: v = 30'd31;
      26: v = 30'd15;
      27: v = 30'd7;
      28: v = 30'd3;
      29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/quaternion_attitude_update.sv =====
// quaternion_attitude_update: pipelined fixed-point quaternion attitude propagation
//
//  channel   direction  signals                         content
//  s_axis    in         tvalid tready tdata[223:0]      quaternion and body rate
//  m_axis    out        tvalid tready tdata[127:0] tuser updated quaternion, small flag
//  cfg       in         cfg_valid_i cfg_ready_o         register index and write data
//
//  one item enters per cycle while no stall holds the pipeline; the pipeline depth includes
//  two 32-stage root extractors, two 32-stage dividers and one stage per cordic step.
//  reset clears all stage valid bits and loads the register defaults.
//  each stage holds while the one after it is full and stalled, so bubbles close up
//  and a stall at the output loses and repeats nothing.
`default_nettype none

module quaternion_attitude_update
  import qau_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // quat_scalar, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z
  input  wire logic [223:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // next_scalar, next_x, next_y, next_z
  output logic [127:0]      m_axis_tdata,
  // small_angle_used
  output logic              m_axis_tuser,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic         cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  localparam int CS       = (CORDIC_STEPS > 32) ? 32 : int'(CORDIC_STEPS);
  localparam int K_SQ     = 0;
  localparam int K_SUM    = 1;
  localparam int K_SQRT1  = 2;
  localparam int K_ANG    = K_SQRT1 + 32;
  localparam int K_MOD    = K_ANG + 1;
  localparam int K_FOLD   = K_MOD + 5;
  localparam int K_CORD   = K_FOLD + 1;
  localparam int K_DQ     = K_CORD + CS;
  localparam int K_SMALL  = K_DQ + 1;
  localparam int K_DIV1   = K_SMALL + 1;
  localparam int K_NORM   = K_DIV1 + 32;
  localparam int K_MUL    = K_NORM + 1;
  localparam int K_ADD    = K_MUL + 1;
  localparam int K_MAG    = K_ADD + 1;
  localparam int K_MAX1   = K_MAG + 1;
  localparam int K_MAX2   = K_MAX1 + 1;
  localparam int K_SH     = K_MAX2 + 1;
  localparam int K_SQ2    = K_SH + 11;
  localparam int K_SUM2   = K_SQ2 + 1;
  localparam int K_SQRT2  = K_SUM2 + 1;
  localparam int K_DSET   = K_SQRT2 + 32;
  localparam int K_DIV2   = K_DSET + 1;
  localparam int K_OUT    = K_DIV2 + 32;
  localparam int NS       = K_OUT + 1;

  logic [31:0] step_time_q;
  logic [15:0] small_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q   <= STEP_TIME_RST;
      small_limit_q <= SMALL_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STEP_TIME:   step_time_q   <= cfg_data_i;
        CFG_SMALL_LIMIT: small_limit_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // work of one pipeline stage, chosen by its position
  function automatic item_t stage_fn(input int k, input item_t x, input logic [31:0] st,
                                     input logic [15:0] lim);
    item_t                 y;
    int                    b;
    int                    s;
    logic [65:0]           t66;
    logic [63:0]           t64;
    logic [38:0]           tp;
    logic [63:0]           prod;
    logic signed [34:0]    h;
    logic signed [33:0]    dx;
    logic signed [33:0]    dy;
    logic signed [33:0]    at;
    logic [33:0]           smag;
    logic signed [36:0]    c37;
    logic signed [68:0]    pw;
    logic signed [63:0]    pt;
    logic [3:0][31:0]      rv;
    y = x;
    if (k == K_SQ) begin
      for (int i = 0; i < 3; i++) begin
        y.pr[i] = 64'($signed(x.r[i]) * $signed(x.r[i]));
      end
    end else if (k == K_SUM || k == K_SUM2) begin
      y.a    = {2'b00, x.pr[0] + x.pr[1] + x.pr[2] + ((k == K_SUM2) ? x.pr[3] : 64'd0)};
      y.root = '0;
    end else if ((k >= K_SQRT1 && k < K_ANG) || (k >= K_SQRT2 && k < K_DSET)) begin
      // one root bit per stage
      b   = (k < K_ANG) ? (31 - (k - K_SQRT1)) : (31 - (k - K_SQRT2));
      t66 = ({34'd0, x.root} << (b + 1)) + (66'd1 << (2 * b));
      if (x.a >= t66) begin
        y.a    = x.a - t66;
        y.root = x.root | (32'd1 << b);
      end
    end else if (k == K_ANG) begin
      y.om        = x.root;
      y.small_ang = (x.root < {16'd0, lim}) || (x.root == 32'd0);
      prod        = 64'(x.root) * 64'(st);
      y.ang       = {2'b00, prod[63:27]};
    end else if (k >= K_MOD && k < K_FOLD) begin
      b  = 4 - (k - K_MOD);
      tp = 39'(TWO_PI_U) << b;
      if (x.ang >= tp) begin
        y.ang = x.ang - tp;
      end
    end else if (k == K_FOLD) begin
      h      = $signed({2'b00, x.ang[32:0]});
      y.negc = 1'b0;
      if (h > ANG_PI) begin
        h = h - ANG_TWO;
      end
      if (h > ANG_HALF) begin
        h      = ANG_PI - h;
        y.negc = 1'b1;
      end else if (h < -ANG_HALF) begin
        h      = -ANG_PI - h;
        y.negc = 1'b1;
      end
      y.cz = h[33:0];
      y.cx = GAIN;
      y.cy = '0;
    end else if (k >= K_CORD && k < K_DQ) begin
      b  = k - K_CORD;
      dx = $signed(x.cy) >>> b;
      dy = $signed(x.cx) >>> b;
      at = $signed({4'b0000, atan_q30(b)});
      if (!x.cz[33]) begin
        y.cx = x.cx - dx;
        y.cy = x.cy + dy;
        y.cz = x.cz - at;
      end else begin
        y.cx = x.cx + dx;
        y.cy = x.cy - dy;
        y.cz = x.cz + at;
      end
    end else if (k == K_DQ) begin
      c37     = 37'($signed(x.cx));
      y.dv[0] = x.negc ? -c37 : c37;
      smag    = x.cy[33] ? (~x.cy + 34'd1) : x.cy;
      for (int i = 0; i < 3; i++) begin
        y.num[i] = 64'(mag32(x.r[i])) * 64'(smag[31:0]);
      end
      y.den = x.om;
      y.quo = '0;
    end else if (k == K_SMALL) begin
      if (x.small_ang) begin
        for (int i = 0; i < 3; i++) begin
          prod        = 64'(mag32(x.r[i])) * 64'(st);
          y.dv[i + 1] = x.r[i][31] ? 37'(prod[63:27]) : -37'(prod[63:27]);
        end
      end
    end else if ((k >= K_DIV1 && k < K_NORM) || (k >= K_DIV2 && k < K_OUT)) begin
      // one quotient bit per stage
      b   = (k < K_NORM) ? (31 - (k - K_DIV1)) : (31 - (k - K_DIV2));
      t64 = {32'd0, x.den} << b;
      for (int i = 0; i < 4; i++) begin
        if (x.num[i] >= t64) begin
          y.num[i] = x.num[i] - t64;
          y.quo[i] = x.quo[i] | (32'd1 << b);
        end
      end
    end else if (k == K_NORM) begin
      if (!x.small_ang) begin
        for (int i = 0; i < 3; i++) begin
          y.dv[i + 1] = (x.r[i][31] == x.cy[33]) ? -37'(x.quo[i]) : 37'(x.quo[i]);
        end
      end
    end else if (k == K_MUL) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pw              = $signed(x.dv[i]) * $signed(x.q[j]);
          pt              = $signed(pw[63:0]);
          y.pr[4 * i + j] = pt >>> 2;
        end
      end
    end else if (k == K_ADD) begin
      // hamilton product, increment on the left
      y.p[0] = x.pr[0] - x.pr[5] - x.pr[10] - x.pr[15];
      y.p[1] = x.pr[1] + x.pr[4] + x.pr[11] - x.pr[14];
      y.p[2] = x.pr[2] - x.pr[7] + x.pr[8] + x.pr[13];
      y.p[3] = x.pr[3] + x.pr[6] - x.pr[9] + x.pr[12];
    end else if (k == K_MAG) begin
      for (int i = 0; i < 4; i++) begin
        y.cm[i]   = x.p[i][63] ? (~x.p[i] + 64'd1) : x.p[i];
        y.pneg[i] = x.p[i][63];
      end
    end else if (k == K_MAX1) begin
      y.m  = (x.cm[0] > x.cm[1]) ? x.cm[0] : x.cm[1];
      y.m2 = (x.cm[2] > x.cm[3]) ? x.cm[2] : x.cm[3];
    end else if (k == K_MAX2) begin
      y.m    = (x.m > x.m2) ? x.m : x.m2;
      y.zero = (x.m == 64'd0) && (x.m2 == 64'd0);
    end else if (k >= K_SH && k < K_SQ2) begin
      // bring the largest part into [2^29, 2^30), one shift amount per stage
      s = k - K_SH;
      if (s < 6) begin
        b = 32 >> s;
        if (x.m >= (64'd1 << (29 + b))) begin
          y.m = x.m >> b;
          for (int i = 0; i < 4; i++) begin
            y.cm[i] = x.cm[i] >> b;
          end
        end
      end else begin
        b = 16 >> (s - 6);
        if (x.m < (64'd1 << (30 - b))) begin
          y.m = x.m << b;
          for (int i = 0; i < 4; i++) begin
            y.cm[i] = x.cm[i] << b;
          end
        end
      end
    end else if (k == K_SQ2) begin
      for (int i = 0; i < 4; i++) begin
        y.pr[i] = 64'(x.cm[i][30:0]) * 64'(x.cm[i][30:0]);
      end
    end else if (k == K_DSET) begin
      y.den = x.root;
      for (int i = 0; i < 4; i++) begin
        y.num[i] = x.cm[i] << 30;
      end
      y.quo = '0;
    end else if (k == K_OUT) begin
      for (int i = 0; i < 4; i++) begin
        rv[i] = x.pneg[i] ? -x.quo[i] : x.quo[i];
      end
      if (rv[0][31]) begin
        for (int i = 0; i < 4; i++) begin
          rv[i] = -rv[i];
        end
      end
      if (x.zero) begin
        rv[0] = ONE_Q30;
        rv[1] = '0;
        rv[2] = '0;
        rv[3] = '0;
      end
      y.res = rv;
    end
    return y;
  endfunction

  item_t     in_item;
  item_t     pipe_q [NS];
  logic      vld_q  [NS];
  logic      en     [NS];

  always_comb begin
    in_item = '0;
    for (int i = 0; i < 4; i++) begin
      in_item.q[i] = s_axis_tdata[32 * i +: 32];
    end
    for (int i = 0; i < 3; i++) begin
      in_item.r[i] = s_axis_tdata[128 + 32 * i +: 32];
    end
  end

  // a stage loads when empty or when the stage after it moves on
  always_comb begin
    en[NS - 1] = !vld_q[NS - 1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k + 1];
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    item_t src;
    logic  src_vld;
    if (g == 0) begin : g_first
      assign src     = in_item;
      assign src_vld = s_axis_tvalid;
    end else begin : g_next
      assign src     = pipe_q[g - 1];
      assign src_vld = vld_q[g - 1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en[g]) begin
        vld_q[g] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[g]) begin
        pipe_q[g] <= stage_fn(g, src, step_time_q, small_limit_q);
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NS - 1];
  assign m_axis_tdata  = {pipe_q[NS - 1].res[3], pipe_q[NS - 1].res[2],
                          pipe_q[NS - 1].res[1], pipe_q[NS - 1].res[0]};
  assign m_axis_tuser  = pipe_q[NS - 1].small_ang;

endmodule

`default_nettype wire
